FILE: hdl/soft_timer_bank_macros.svh
// Assertion helpers for the timer bank; clock clk, reset arst_n.
`ifndef SOFT_TIMER_BANK_MACROS_SVH
`define SOFT_TIMER_BANK_MACROS_SVH

`ifndef SYNTHESIS

`define STB_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define STB_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define STB_ASSERT_IMP(name, ante, cons)

`define STB_ASSERT_NXT(name, ante, cons)

`endif

`endif

FILE: hdl/stb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

	localparam int CMD_W       = 3;
	localparam int ID_W        = 8;
	localparam int DATA_W      = 32;
	localparam int PRESCALE_W  = 4;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 40;
	localparam int M_PAD_W     = M_TDATA_W - (1 + DATA_W + 1);

	localparam logic [PRESCALE_W-1:0] RUN_TIME_DIVISOR = 4'd10;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 3'd0,
		CMD_START_ONCE = 3'd1,
		CMD_START_AUTO = 3'd2,
		CMD_STOP       = 3'd3,
		CMD_CHECK      = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/stb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/soft_timer_bank.sv
// Bank of NUM_TIMERS countdown timers with a 32-bit run-time counter.
// Requests arrive on the s_ group: s_tdata carries cmd, timer_id and period.
// Each request yields one result on the m_ group: expired, run_time, bad_id.
// Configuration: cfg_we writes cfg_wdata into the divide-by-ten select; write
// it only while the bank is idle.
// Latency: the result is presented the cycle after the request is taken.
// Start, stop and check leave the bank idle for the next request. A tick
// occupies the bank from its accepting cycle through a sweep state, in which one
// shared decrement-and-compare unit walks the count memory one timer per cycle,
// read and write-back overlapped, and a drain state that writes the last timer back.
// The result register decouples the sides: a new request is taken while the
// previous result is being taken, but not while it is held by a stall on
// m_tready, nor during a tick's sweep and drain states.
// Reset clears valid bits, flags, modes, divide-by-ten select, run-time counter
// and prescaler; memory counts and reloads are masked by per-timer valid bits.
`timescale 1ns / 1ps
`default_nettype none

module soft_timer_bank #(
	parameter int NUM_TIMERS = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_wdata,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// cmd[2:0], timer_id[10:3], period[42:11], zero fill
	input  wire logic [stb_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// expired[0], run_time[32:1], bad_id[33], zero fill
	output logic      [stb_pkg::M_TDATA_W-1:0] m_tdata
);

`include "soft_timer_bank_macros.svh"

	localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TIMERS - 1);

	logic [stb_pkg::CMD_W-1:0]  cmd;
	logic [stb_pkg::ID_W-1:0]   timer_id;
	logic [stb_pkg::DATA_W-1:0] period;
	logic [IdxW-1:0]            id_idx;
	logic                       id_ok;
	logic                       s_acc;
	logic                       is_tick, is_start, is_stop, is_check, is_timer_cmd;

	stb_pkg::state_t state_q, state_d;
	logic [IdxW-1:0] rd_idx_q, rd_idx_d;

	logic            valid_s1;
	logic [IdxW-1:0] idx_s1;

	logic [NUM_TIMERS-1:0] valid_q, flag_q, auto_q;
	logic                  div_ten_q;
	logic [stb_pkg::DATA_W-1:0]     run_time_q, run_time_d;
	logic [stb_pkg::PRESCALE_W-1:0] prescale_q, prescale_d, prescale_inc;

	logic                       rem_we, rld_we;
	logic [IdxW-1:0]            rem_waddr;
	logic [stb_pkg::DATA_W-1:0] rem_wdata;
	logic [stb_pkg::DATA_W-1:0] rem_rdata, rld_rdata;
	logic [stb_pkg::DATA_W-1:0] rem_cur, rld_cur, rem_dec, rem_new;
	logic                       hit, fire, sw_we;

	logic                        m_tvalid_q;
	logic [stb_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                        expired, bad_id;

	assign cmd      = s_tdata[2:0];
	assign timer_id = s_tdata[10:3];
	assign period   = s_tdata[42:11];
	assign id_idx   = timer_id[IdxW-1:0];
	assign id_ok    = timer_id < stb_pkg::ID_W'(NUM_TIMERS);

	assign is_tick      = cmd == stb_pkg::CMD_TICK;
	assign is_start     = (cmd == stb_pkg::CMD_START_ONCE) || (cmd == stb_pkg::CMD_START_AUTO);
	assign is_stop      = cmd == stb_pkg::CMD_STOP;
	assign is_check     = cmd == stb_pkg::CMD_CHECK;
	assign is_timer_cmd = is_start || is_stop || is_check;

	assign s_tready = (state_q == stb_pkg::ST_IDLE) && (!m_tvalid_q || m_tready);
	assign s_acc    = s_tvalid && s_tready;

	// sweep sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= stb_pkg::ST_IDLE;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_idx_q <= rd_idx_d;
			valid_s1 <= state_q == stb_pkg::ST_SWEEP;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
	end

	always_comb begin
		state_d  = state_q;
		rd_idx_d = rd_idx_q;
		unique case (state_q)
			stb_pkg::ST_IDLE: begin
				if (s_acc && is_tick) begin
					state_d  = stb_pkg::ST_SWEEP;
					rd_idx_d = '0;
				end
			end
			stb_pkg::ST_SWEEP: begin
				if (rd_idx_q == LastIdx) begin
					state_d = stb_pkg::ST_DRAIN;
				end else begin
					rd_idx_d = rd_idx_q + 1'b1;
				end
			end
			stb_pkg::ST_DRAIN: begin
				state_d = stb_pkg::ST_IDLE;
			end
			default: begin
				state_d = stb_pkg::ST_IDLE;
			end
		endcase
	end

	// shared decrement and compare
	assign rem_cur = valid_q[idx_s1] ? rem_rdata : '0;
	assign rld_cur = valid_q[idx_s1] ? rld_rdata : '0;
	assign rem_dec = rem_cur - 1'b1;
	assign hit     = rem_cur != '0;
	assign fire    = hit && (rem_dec == '0);
	assign rem_new = (fire && auto_q[idx_s1]) ? rld_cur : rem_dec;
	assign sw_we   = valid_s1 && hit;

	assign rem_we    = sw_we || (s_acc && id_ok && (is_start || (is_stop && valid_q[id_idx])));
	assign rem_waddr = valid_s1 ? idx_s1 : id_idx;
	assign rem_wdata = valid_s1 ? rem_new : (is_start ? period : '0);
	assign rld_we    = s_acc && id_ok && is_start;

	stb_ram #(
		.WIDTH(stb_pkg::DATA_W),
		.DEPTH(NUM_TIMERS)
	) u_rem_ram (
		.clk  (clk),
		.we   (rem_we),
		.waddr(rem_waddr),
		.wdata(rem_wdata),
		.raddr(rd_idx_q),
		.rdata(rem_rdata)
	);

	stb_ram #(
		.WIDTH(stb_pkg::DATA_W),
		.DEPTH(NUM_TIMERS)
	) u_rld_ram (
		.clk  (clk),
		.we   (rld_we),
		.waddr(id_idx),
		.wdata(period),
		.raddr(rd_idx_q),
		.rdata(rld_rdata)
	);

	// per-timer flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			flag_q  <= '0;
			auto_q  <= '0;
		end else begin
			if (valid_s1 && fire) begin
				flag_q[idx_s1] <= 1'b1;
			end
			if (s_acc && id_ok) begin
				if (is_start) begin
					valid_q[id_idx] <= 1'b1;
					flag_q[id_idx]  <= 1'b0;
					auto_q[id_idx]  <= cmd == stb_pkg::CMD_START_AUTO;
				end else if (is_stop) begin
					flag_q[id_idx] <= 1'b0;
					auto_q[id_idx] <= 1'b0;
				end else if (is_check) begin
					flag_q[id_idx] <= 1'b0;
				end
			end
		end
	end

	// run-time counter
	assign prescale_inc = prescale_q + 1'b1;

	always_comb begin
		run_time_d = run_time_q;
		prescale_d = prescale_q;
		if (is_tick) begin
			if (!div_ten_q) begin
				run_time_d = run_time_q + 1'b1;
			end else if (prescale_inc >= stb_pkg::RUN_TIME_DIVISOR) begin
				prescale_d = '0;
				run_time_d = run_time_q + 1'b1;
			end else begin
				prescale_d = prescale_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_ten_q  <= 1'b0;
			run_time_q <= '0;
			prescale_q <= '0;
		end else begin
			if (cfg_we) begin
				div_ten_q <= cfg_wdata;
			end
			if (s_acc) begin
				run_time_q <= run_time_d;
				prescale_q <= prescale_d;
			end
		end
	end

	// result register
	assign expired = s_acc && is_check && id_ok && flag_q[id_idx];
	assign bad_id  = is_timer_cmd && !id_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_acc) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_tdata_q <= {{stb_pkg::M_PAD_W{1'b0}}, bad_id, run_time_d, expired};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`STB_ASSERT_NXT(a_tick_starts_sweep, s_acc && is_tick,
		(state_q == stb_pkg::ST_SWEEP) && (rd_idx_q == '0))
	`STB_ASSERT_NXT(a_cmd_stays_idle, s_acc && !is_tick, state_q == stb_pkg::ST_IDLE)
	`STB_ASSERT_IMP(a_wb_only_in_sweep, valid_s1, state_q != stb_pkg::ST_IDLE)
	`STB_ASSERT_IMP(a_prescale_range, 1'b1, prescale_q < stb_pkg::RUN_TIME_DIVISOR)

endmodule

`default_nettype wire
